// File: rtl/rtn_pkg.sv
package rtn_pkg;

   localparam int COORD_WIDTH_DEF   = 32;
   localparam int FRACTION_BITS_DEF = 16;
   localparam int MAX_TRIANGLES_DEF = 65536;

   localparam int DIST_W      = 31;
   localparam int INDEX_W     = 16;
   localparam int CSR_INDEX_W = 3;

   localparam logic [63:0] TEN_POW_10 = 64'd10000000000;

   // Register indexes of the configuration port.
   localparam logic [CSR_INDEX_W-1:0] CSR_ORIGIN_X = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_ORIGIN_Y = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_ORIGIN_Z = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_DIR_X    = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_DIR_Y    = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_DIR_Z    = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] CSR_MAX_DIST = 3'd6;
   localparam logic [CSR_INDEX_W-1:0] CSR_CULL     = 3'd7;

   // Micro-operation codes.
   localparam int OP_W = 4;
   localparam logic [OP_W-1:0] OP_LD     = 4'd0;
   localparam logic [OP_W-1:0] OP_ADD    = 4'd1;
   localparam logic [OP_W-1:0] OP_SUB    = 4'd2;
   localparam logic [OP_W-1:0] OP_MUL    = 4'd3;
   localparam logic [OP_W-1:0] OP_DIV    = 4'd4;
   localparam logic [OP_W-1:0] OP_SGN    = 4'd5;
   localparam logic [OP_W-1:0] OP_CULL   = 4'd6;
   localparam logic [OP_W-1:0] OP_CNEG   = 4'd7;
   localparam logic [OP_W-1:0] OP_RJNEG  = 4'd8;
   localparam logic [OP_W-1:0] OP_RJPOS  = 4'd9;
   localparam logic [OP_W-1:0] OP_RJNPOS = 4'd10;
   localparam logic [OP_W-1:0] OP_FIN    = 4'd11;

   // Register file slots. The first ones are loaded from the word, the ray and constants.
   localparam int RF_DEPTH = 40;
   localparam int ADDR_W   = 6;
   localparam logic [ADDR_W-1:0] A_AX   = 6'd0;
   localparam logic [ADDR_W-1:0] A_AY   = 6'd1;
   localparam logic [ADDR_W-1:0] A_AZ   = 6'd2;
   localparam logic [ADDR_W-1:0] A_BX   = 6'd3;
   localparam logic [ADDR_W-1:0] A_BY   = 6'd4;
   localparam logic [ADDR_W-1:0] A_BZ   = 6'd5;
   localparam logic [ADDR_W-1:0] A_CX   = 6'd6;
   localparam logic [ADDR_W-1:0] A_CY   = 6'd7;
   localparam logic [ADDR_W-1:0] A_CZ   = 6'd8;
   localparam logic [ADDR_W-1:0] A_OX   = 6'd9;
   localparam logic [ADDR_W-1:0] A_OY   = 6'd10;
   localparam logic [ADDR_W-1:0] A_OZ   = 6'd11;
   localparam logic [ADDR_W-1:0] A_DX   = 6'd12;
   localparam logic [ADDR_W-1:0] A_DY   = 6'd13;
   localparam logic [ADDR_W-1:0] A_DZ   = 6'd14;
   localparam logic [ADDR_W-1:0] A_MAXD = 6'd15;
   localparam logic [ADDR_W-1:0] A_TEN  = 6'd16;
   localparam logic [ADDR_W-1:0] A_P3F  = 6'd17;
   localparam logic [ADDR_W-1:0] A_PF   = 6'd18;
   localparam logic [ADDR_W-1:0] A_E1X  = 6'd19;
   localparam logic [ADDR_W-1:0] A_E1Y  = 6'd20;
   localparam logic [ADDR_W-1:0] A_E1Z  = 6'd21;
   localparam logic [ADDR_W-1:0] A_E2X  = 6'd22;
   localparam logic [ADDR_W-1:0] A_E2Y  = 6'd23;
   localparam logic [ADDR_W-1:0] A_E2Z  = 6'd24;
   localparam logic [ADDR_W-1:0] A_SX   = 6'd25;
   localparam logic [ADDR_W-1:0] A_SY   = 6'd26;
   localparam logic [ADDR_W-1:0] A_SZ   = 6'd27;
   localparam logic [ADDR_W-1:0] A_HX   = 6'd28;
   localparam logic [ADDR_W-1:0] A_HY   = 6'd29;
   localparam logic [ADDR_W-1:0] A_HZ   = 6'd30;
   localparam logic [ADDR_W-1:0] A_QX   = 6'd31;
   localparam logic [ADDR_W-1:0] A_QY   = 6'd32;
   localparam logic [ADDR_W-1:0] A_QZ   = 6'd33;
   localparam logic [ADDR_W-1:0] A_DET  = 6'd34;
   localparam logic [ADDR_W-1:0] A_UN   = 6'd35;
   localparam logic [ADDR_W-1:0] A_VN   = 6'd36;
   localparam logic [ADDR_W-1:0] A_TN   = 6'd37;
   localparam logic [ADDR_W-1:0] A_T1   = 6'd38;
   localparam logic [ADDR_W-1:0] A_T2   = 6'd39;

   localparam int STEP_W    = 7;
   localparam int LAST_STEP = 90;

   typedef struct packed {
      logic [OP_W-1:0]   op;
      logic [ADDR_W-1:0] dst;
      logic [ADDR_W-1:0] src_a;
      logic [ADDR_W-1:0] src_b;
   } uop_type;

   typedef struct packed {
      logic              load;
      logic              exec;
      logic [ADDR_W-1:0] rd_a;
      logic [ADDR_W-1:0] rd_b;
      uop_type           uop;
   } dp_cmd_type;

   typedef struct packed {
      logic unit_done;
      logic out_free;
   } dp_status_type;

   function automatic int max_int(int a, int b);
      return (a > b) ? a : b;
   endfunction

   function automatic uop_type mk(logic [OP_W-1:0] op, logic [ADDR_W-1:0] d,
                                  logic [ADDR_W-1:0] a, logic [ADDR_W-1:0] b);
      uop_type u;
      u.op    = op;
      u.dst   = d;
      u.src_a = a;
      u.src_b = b;
      return u;
   endfunction

   // Micro-program for one triangle. The first steps load the operands.
   function automatic uop_type ucode(logic [STEP_W-1:0] step);
      uop_type u;
      u = mk(OP_FIN, A_T1, A_T1, A_T1);
      if (step <= STEP_W'(A_PF)) begin
         u = mk(OP_LD, step[ADDR_W-1:0], step[ADDR_W-1:0], step[ADDR_W-1:0]);
      end else begin
         case (step)
            7'd19: u = mk(OP_SUB, A_E1X, A_BX, A_AX);
            7'd20: u = mk(OP_SUB, A_E1Y, A_BY, A_AY);
            7'd21: u = mk(OP_SUB, A_E1Z, A_BZ, A_AZ);
            7'd22: u = mk(OP_SUB, A_E2X, A_CX, A_AX);
            7'd23: u = mk(OP_SUB, A_E2Y, A_CY, A_AY);
            7'd24: u = mk(OP_SUB, A_E2Z, A_CZ, A_AZ);
            7'd25: u = mk(OP_SUB, A_SX, A_OX, A_AX);
            7'd26: u = mk(OP_SUB, A_SY, A_OY, A_AY);
            7'd27: u = mk(OP_SUB, A_SZ, A_OZ, A_AZ);
            7'd28: u = mk(OP_MUL, A_T1, A_E2Z, A_DY);
            7'd29: u = mk(OP_MUL, A_T2, A_E2Y, A_DZ);
            7'd30: u = mk(OP_SUB, A_HX, A_T1, A_T2);
            7'd31: u = mk(OP_MUL, A_T1, A_E2X, A_DZ);
            7'd32: u = mk(OP_MUL, A_T2, A_E2Z, A_DX);
            7'd33: u = mk(OP_SUB, A_HY, A_T1, A_T2);
            7'd34: u = mk(OP_MUL, A_T1, A_E2Y, A_DX);
            7'd35: u = mk(OP_MUL, A_T2, A_E2X, A_DY);
            7'd36: u = mk(OP_SUB, A_HZ, A_T1, A_T2);
            7'd37: u = mk(OP_MUL, A_T1, A_HX, A_E1X);
            7'd38: u = mk(OP_MUL, A_T2, A_HY, A_E1Y);
            7'd39: u = mk(OP_ADD, A_T1, A_T1, A_T2);
            7'd40: u = mk(OP_MUL, A_T2, A_HZ, A_E1Z);
            7'd41: u = mk(OP_ADD, A_DET, A_T1, A_T2);
            7'd42: u = mk(OP_SGN, A_DET, A_DET, A_DET);
            7'd43: u = mk(OP_CULL, A_DET, A_DET, A_DET);
            7'd44: u = mk(OP_CNEG, A_DET, A_DET, A_DET);
            7'd45: u = mk(OP_MUL, A_T1, A_DET, A_TEN);
            7'd46: u = mk(OP_SUB, A_T1, A_T1, A_P3F);
            7'd47: u = mk(OP_RJNEG, A_T1, A_T1, A_T1);
            7'd48: u = mk(OP_MUL, A_T1, A_SY, A_E1Z);
            7'd49: u = mk(OP_MUL, A_T2, A_SZ, A_E1Y);
            7'd50: u = mk(OP_SUB, A_QX, A_T1, A_T2);
            7'd51: u = mk(OP_MUL, A_T1, A_SZ, A_E1X);
            7'd52: u = mk(OP_MUL, A_T2, A_SX, A_E1Z);
            7'd53: u = mk(OP_SUB, A_QY, A_T1, A_T2);
            7'd54: u = mk(OP_MUL, A_T1, A_SX, A_E1Y);
            7'd55: u = mk(OP_MUL, A_T2, A_SY, A_E1X);
            7'd56: u = mk(OP_SUB, A_QZ, A_T1, A_T2);
            7'd57: u = mk(OP_MUL, A_T1, A_HX, A_SX);
            7'd58: u = mk(OP_MUL, A_T2, A_HY, A_SY);
            7'd59: u = mk(OP_ADD, A_T1, A_T1, A_T2);
            7'd60: u = mk(OP_MUL, A_T2, A_HZ, A_SZ);
            7'd61: u = mk(OP_ADD, A_UN, A_T1, A_T2);
            7'd62: u = mk(OP_CNEG, A_UN, A_UN, A_UN);
            7'd63: u = mk(OP_MUL, A_T1, A_QX, A_DX);
            7'd64: u = mk(OP_MUL, A_T2, A_QY, A_DY);
            7'd65: u = mk(OP_ADD, A_T1, A_T1, A_T2);
            7'd66: u = mk(OP_MUL, A_T2, A_QZ, A_DZ);
            7'd67: u = mk(OP_ADD, A_VN, A_T1, A_T2);
            7'd68: u = mk(OP_CNEG, A_VN, A_VN, A_VN);
            7'd69: u = mk(OP_MUL, A_T1, A_QX, A_E2X);
            7'd70: u = mk(OP_MUL, A_T2, A_QY, A_E2Y);
            7'd71: u = mk(OP_ADD, A_T1, A_T1, A_T2);
            7'd72: u = mk(OP_MUL, A_T2, A_QZ, A_E2Z);
            7'd73: u = mk(OP_ADD, A_TN, A_T1, A_T2);
            7'd74: u = mk(OP_CNEG, A_TN, A_TN, A_TN);
            7'd75: u = mk(OP_RJNEG, A_UN, A_UN, A_UN);
            7'd76: u = mk(OP_SUB, A_T1, A_UN, A_DET);
            7'd77: u = mk(OP_RJPOS, A_T1, A_T1, A_T1);
            7'd78: u = mk(OP_RJNEG, A_VN, A_VN, A_VN);
            7'd79: u = mk(OP_ADD, A_T1, A_UN, A_VN);
            7'd80: u = mk(OP_SUB, A_T1, A_T1, A_DET);
            7'd81: u = mk(OP_RJPOS, A_T1, A_T1, A_T1);
            7'd82: u = mk(OP_MUL, A_T1, A_TN, A_TEN);
            7'd83: u = mk(OP_SUB, A_T1, A_T1, A_DET);
            7'd84: u = mk(OP_RJNPOS, A_T1, A_T1, A_T1);
            7'd85: u = mk(OP_MUL, A_TN, A_TN, A_PF);
            7'd86: u = mk(OP_MUL, A_T2, A_DET, A_MAXD);
            7'd87: u = mk(OP_SUB, A_T1, A_TN, A_T2);
            7'd88: u = mk(OP_RJPOS, A_T1, A_T1, A_T1);
            7'd89: u = mk(OP_DIV, A_TN, A_TN, A_DET);
            default: u = mk(OP_FIN, A_T1, A_T1, A_T1);
         endcase
      end
      return u;
   endfunction

endpackage

// File: rtl/rtn_ctrl.sv
module rtn_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   output rtn_pkg::dp_cmd_type    cmd,
   input  rtn_pkg::dp_status_type status
);
   import rtn_pkg::*;

   localparam logic [1:0] S_IDLE  = 2'd0;
   localparam logic [1:0] S_FETCH = 2'd1;
   localparam logic [1:0] S_EXEC  = 2'd2;
   localparam logic [1:0] S_WAIT  = 2'd3;

   logic [1:0]        state_ff, state_in;
   logic [STEP_W-1:0] step_ff, step_in;
   uop_type           uop;
   logic              is_unit;

   assign uop     = ucode(step_ff);
   assign is_unit = (uop.op == OP_MUL) || (uop.op == OP_DIV);

   always_comb begin
      req_ready = (state_ff == S_IDLE);
      cmd.load  = req_valid && (state_ff == S_IDLE);
      cmd.exec  = (state_ff == S_EXEC) && ((uop.op != OP_FIN) || status.out_free);
      cmd.rd_a  = uop.src_a;
      cmd.rd_b  = uop.src_b;
      cmd.uop   = uop;
      state_in  = state_ff;
      step_in   = step_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               state_in = S_FETCH;
               step_in  = '0;
            end
         end
         S_FETCH: state_in = S_EXEC;
         S_EXEC: begin
            if (cmd.exec) begin
               if (is_unit) begin
                  state_in = S_WAIT;
               end else if (step_ff == STEP_W'(LAST_STEP)) begin
                  state_in = S_IDLE;
               end else begin
                  state_in = S_FETCH;
                  step_in  = step_ff + 1'b1;
               end
            end
         end
         S_WAIT: begin
            if (status.unit_done) begin
               state_in = S_FETCH;
               step_in  = step_ff + 1'b1;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

endmodule

// File: rtl/rtn_datapath.sv
module rtn_datapath #(
   parameter int COORD_WIDTH   = rtn_pkg::COORD_WIDTH_DEF,
   parameter int FRACTION_BITS = rtn_pkg::FRACTION_BITS_DEF,
   parameter int MAX_TRIANGLES = rtn_pkg::MAX_TRIANGLES_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_we,
   input  logic [rtn_pkg::CSR_INDEX_W-1:0]       csr_index,
   input  logic [rtn_pkg::max_int(COORD_WIDTH, rtn_pkg::DIST_W)-1:0] csr_wdata,
   input  logic signed [COORD_WIDTH-1:0]         req_a_x,
   input  logic signed [COORD_WIDTH-1:0]         req_a_y,
   input  logic signed [COORD_WIDTH-1:0]         req_a_z,
   input  logic signed [COORD_WIDTH-1:0]         req_b_x,
   input  logic signed [COORD_WIDTH-1:0]         req_b_y,
   input  logic signed [COORD_WIDTH-1:0]         req_b_z,
   input  logic signed [COORD_WIDTH-1:0]         req_c_x,
   input  logic signed [COORD_WIDTH-1:0]         req_c_y,
   input  logic signed [COORD_WIDTH-1:0]         req_c_z,
   input  logic                                  req_last_triangle,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic                                  rsp_hit,
   output logic [rtn_pkg::DIST_W-1:0]            rsp_distance,
   output logic [rtn_pkg::INDEX_W-1:0]           rsp_triangle_index,
   input  rtn_pkg::dp_cmd_type                   cmd,
   output rtn_pkg::dp_status_type                status
);
   import rtn_pkg::*;

   localparam int CW    = COORD_WIDTH;
   localparam int W     = 3 * COORD_WIDTH + FRACTION_BITS + 48;
   localparam int MB    = max_int(COORD_WIDTH + 2, 36);
   localparam int CNT_W = $clog2(MB + 1);
   localparam int TRI_W = $clog2(MAX_TRIANGLES);
   localparam logic [W-1:0]     P3F_VAL = {{(W-1){1'b0}}, 1'b1} << (3 * FRACTION_BITS);
   localparam logic [W-1:0]     PF_VAL  = {{(W-1){1'b0}}, 1'b1} << FRACTION_BITS;
   localparam logic [CW-1:0]    DIRZ_RESET = CW'(64'd1 << FRACTION_BITS);
   localparam logic [TRI_W-1:0] TRI_LAST = TRI_W'(MAX_TRIANGLES - 1);

   // Ray registers.
   logic signed [CW-1:0] origin_x_ff, origin_y_ff, origin_z_ff;
   logic signed [CW-1:0] dir_x_ff, dir_y_ff, dir_z_ff;
   logic [DIST_W-1:0]    max_distance_ff;
   logic                 cull_ff;

   // Captured triangle.
   logic signed [CW-1:0] ax_ff, ay_ff, az_ff, bx_ff, by_ff, bz_ff, cx_ff, cy_ff, cz_ff;
   logic                 last_ff;

   // Register file and its registered read ports.
   logic signed [W-1:0] rf [RF_DEPTH];
   logic signed [W-1:0] rda_ff, rdb_ff;
   logic                wr_en;
   logic signed [W-1:0] wr_data, simple_res, ext_val;
   logic                simple_wr;

   // Flags of the triangle under test.
   logic neg_ff, reject_ff;

   // Shared shift-add multiplier / restoring divider.
   logic              busy_ff, is_div_ff, mneg_ff;
   logic [CNT_W-1:0]  cnt_ff;
   logic [W-1:0]      acc_ff, shf_ff;
   logic [MB-1:0]     mplier_ff, b_low, b_mag;
   logic [DIST_W-1:0] quo_ff, dist_ff;
   logic              unit_done;

   // Nearest-hit state and output register.
   logic [DIST_W-1:0] best_ff, best_in;
   logic [TRI_W-1:0]  best_idx_ff, best_idx_in, count_ff;
   logic              any_ff, any_in, better;
   logic              rsp_valid_ff, rsp_hit_ff;
   logic [DIST_W-1:0] rsp_dist_ff;
   logic [INDEX_W-1:0] rsp_idx_ff;
   logic              fin;

   always_ff @(posedge clock) begin
      if (reset) begin
         origin_x_ff     <= '0;
         origin_y_ff     <= '0;
         origin_z_ff     <= '0;
         dir_x_ff        <= '0;
         dir_y_ff        <= '0;
         dir_z_ff        <= DIRZ_RESET;
         max_distance_ff <= '1;
         cull_ff         <= 1'b0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_ORIGIN_X: origin_x_ff     <= csr_wdata[CW-1:0];
            CSR_ORIGIN_Y: origin_y_ff     <= csr_wdata[CW-1:0];
            CSR_ORIGIN_Z: origin_z_ff     <= csr_wdata[CW-1:0];
            CSR_DIR_X:    dir_x_ff        <= csr_wdata[CW-1:0];
            CSR_DIR_Y:    dir_y_ff        <= csr_wdata[CW-1:0];
            CSR_DIR_Z:    dir_z_ff        <= csr_wdata[CW-1:0];
            CSR_MAX_DIST: max_distance_ff <= csr_wdata[DIST_W-1:0];
            CSR_CULL:     cull_ff         <= csr_wdata[0];
            default:      cull_ff         <= cull_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         ax_ff   <= req_a_x;
         ay_ff   <= req_a_y;
         az_ff   <= req_a_z;
         bx_ff   <= req_b_x;
         by_ff   <= req_b_y;
         bz_ff   <= req_b_z;
         cx_ff   <= req_c_x;
         cy_ff   <= req_c_y;
         cz_ff   <= req_c_z;
         last_ff <= req_last_triangle;
      end
   end

   always_comb begin
      unique case (cmd.uop.dst)
         A_AX:    ext_val = W'(ax_ff);
         A_AY:    ext_val = W'(ay_ff);
         A_AZ:    ext_val = W'(az_ff);
         A_BX:    ext_val = W'(bx_ff);
         A_BY:    ext_val = W'(by_ff);
         A_BZ:    ext_val = W'(bz_ff);
         A_CX:    ext_val = W'(cx_ff);
         A_CY:    ext_val = W'(cy_ff);
         A_CZ:    ext_val = W'(cz_ff);
         A_OX:    ext_val = W'(origin_x_ff);
         A_OY:    ext_val = W'(origin_y_ff);
         A_OZ:    ext_val = W'(origin_z_ff);
         A_DX:    ext_val = W'(dir_x_ff);
         A_DY:    ext_val = W'(dir_y_ff);
         A_DZ:    ext_val = W'(dir_z_ff);
         A_MAXD:  ext_val = signed'(W'(max_distance_ff));
         A_TEN:   ext_val = signed'(W'(TEN_POW_10));
         A_P3F:   ext_val = signed'(P3F_VAL);
         A_PF:    ext_val = signed'(PF_VAL);
         default: ext_val = '0;
      endcase
   end

   always_comb begin
      simple_wr  = 1'b1;
      unique case (cmd.uop.op)
         OP_LD:   simple_res = ext_val;
         OP_ADD:  simple_res = rda_ff + rdb_ff;
         OP_SUB:  simple_res = rda_ff - rdb_ff;
         OP_CNEG: simple_res = neg_ff ? -rda_ff : rda_ff;
         default: begin
            simple_res = rda_ff;
            simple_wr  = 1'b0;
         end
      endcase
   end

   assign unit_done = busy_ff && (cnt_ff == '0);
   assign wr_en     = (cmd.exec && simple_wr) || (unit_done && !is_div_ff);
   assign wr_data   = (cmd.exec && simple_wr) ? simple_res
                                              : signed'(mneg_ff ? W'(-acc_ff) : acc_ff);

   always_ff @(posedge clock) begin
      if (wr_en) begin
         rf[cmd.uop.dst] <= wr_data;
      end
      rda_ff <= rf[cmd.rd_a];
      rdb_ff <= rf[cmd.rd_b];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         neg_ff    <= 1'b0;
         reject_ff <= 1'b0;
      end else if (cmd.load) begin
         reject_ff <= 1'b0;
      end else if (cmd.exec) begin
         priority case (cmd.uop.op)
            OP_SGN:    neg_ff    <= rda_ff[W-1];
            OP_CULL:   reject_ff <= reject_ff | (neg_ff & cull_ff);
            OP_RJNEG:  reject_ff <= reject_ff | rda_ff[W-1];
            OP_RJPOS:  reject_ff <= reject_ff | (!rda_ff[W-1] && (rda_ff != '0));
            OP_RJNPOS: reject_ff <= reject_ff | rda_ff[W-1] | (rda_ff == '0);
            default:   reject_ff <= reject_ff;
         endcase
      end
   end

   assign b_low = rdb_ff[MB-1:0];
   assign b_mag = b_low[MB-1] ? -b_low : b_low;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else if (cmd.exec && (cmd.uop.op == OP_MUL)) begin
         busy_ff <= 1'b1;
      end else if (cmd.exec && (cmd.uop.op == OP_DIV)) begin
         busy_ff <= 1'b1;
      end else if (unit_done) begin
         busy_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.exec && (cmd.uop.op == OP_MUL)) begin
         is_div_ff <= 1'b0;
         acc_ff    <= '0;
         shf_ff    <= rda_ff;
         mplier_ff <= b_mag;
         mneg_ff   <= b_low[MB-1];
         cnt_ff    <= CNT_W'(MB);
      end else if (cmd.exec && (cmd.uop.op == OP_DIV)) begin
         is_div_ff <= 1'b1;
         acc_ff    <= rda_ff;
         shf_ff    <= rdb_ff << (DIST_W - 1);
         quo_ff    <= '0;
         mneg_ff   <= 1'b0;
         cnt_ff    <= CNT_W'(DIST_W);
      end else if (busy_ff && (cnt_ff != '0)) begin
         cnt_ff <= cnt_ff - 1'b1;
         if (is_div_ff) begin
            if (acc_ff >= shf_ff) begin
               acc_ff <= acc_ff - shf_ff;
               quo_ff <= {quo_ff[DIST_W-2:0], 1'b1};
            end else begin
               quo_ff <= {quo_ff[DIST_W-2:0], 1'b0};
            end
            shf_ff <= shf_ff >> 1;
         end else begin
            if (mplier_ff[0]) begin
               acc_ff <= acc_ff + shf_ff;
            end
            shf_ff    <= shf_ff << 1;
            mplier_ff <= mplier_ff >> 1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (unit_done && is_div_ff) begin
         dist_ff <= quo_ff;
      end
   end

   // A hit replaces the kept one only when strictly nearer.
   assign fin    = cmd.exec && (cmd.uop.op == OP_FIN);
   assign better = !reject_ff && (!any_ff || (dist_ff < best_ff));

   always_comb begin
      best_in     = better ? dist_ff  : best_ff;
      best_idx_in = better ? count_ff : best_idx_ff;
      any_in      = any_ff | better;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         best_ff      <= '1;
         best_idx_ff  <= '0;
         any_ff       <= 1'b0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (fin && last_ff) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (fin) begin
            if (last_ff) begin
               best_ff      <= '1;
               best_idx_ff  <= '0;
               any_ff       <= 1'b0;
               count_ff     <= '0;
            end else begin
               best_ff     <= best_in;
               best_idx_ff <= best_idx_in;
               any_ff      <= any_in;
               count_ff    <= (count_ff == TRI_LAST) ? '0 : count_ff + 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (fin && last_ff) begin
         rsp_hit_ff  <= any_in;
         rsp_dist_ff <= any_in ? best_in : '0;
         rsp_idx_ff  <= any_in ? INDEX_W'(best_idx_in) : '0;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_hit            = rsp_hit_ff;
   assign rsp_distance       = rsp_dist_ff;
   assign rsp_triangle_index = rsp_idx_ff;
   assign status.unit_done   = unit_done;
   assign status.out_free    = !rsp_valid_ff || rsp_ready;

endmodule

// File: rtl/ray_triangle_nearest_hit.sv
// Nearest ray-triangle hit over a stream of triangles (Moller-Trumbore, exact).
// The ray is set through the csr_ write port: one register per write, taken at
// the clock edge where csr_we is high. The user must write only while the block is
// idle; the block does not enforce it. Triangles arrive on the req_ channel, one
// word per triangle, with a last flag that closes a mesh. A word is taken when
// req_valid and req_ready are both high. Each triangle runs through a micro-coded
// sequence of 91 steps on one register file and one shared shift-add multiplier /
// restoring divider; each of the 28 multiplications takes one multiplier bit per
// cycle and the final division one quotient bit per cycle. req_ready is high only
// between triangles. After the last triangle of a mesh one result word (hit,
// distance, index) is placed in the output register on the rsp_ channel and the
// stream state is cleared. While that word waits for rsp_ready the next triangle
// is still processed, but it holds at its final step until the register frees.
// Reset is synchronous: it loads the ray registers with their defaults, clears
// the nearest-hit state and empties the output register.
module ray_triangle_nearest_hit #(
   parameter int COORD_WIDTH   = rtn_pkg::COORD_WIDTH_DEF,
   parameter int FRACTION_BITS = rtn_pkg::FRACTION_BITS_DEF,
   parameter int MAX_TRIANGLES = rtn_pkg::MAX_TRIANGLES_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_we,
   input  logic [rtn_pkg::CSR_INDEX_W-1:0]       csr_index,
   input  logic [rtn_pkg::max_int(COORD_WIDTH, rtn_pkg::DIST_W)-1:0] csr_wdata,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic signed [COORD_WIDTH-1:0]         req_a_x,
   input  logic signed [COORD_WIDTH-1:0]         req_a_y,
   input  logic signed [COORD_WIDTH-1:0]         req_a_z,
   input  logic signed [COORD_WIDTH-1:0]         req_b_x,
   input  logic signed [COORD_WIDTH-1:0]         req_b_y,
   input  logic signed [COORD_WIDTH-1:0]         req_b_z,
   input  logic signed [COORD_WIDTH-1:0]         req_c_x,
   input  logic signed [COORD_WIDTH-1:0]         req_c_y,
   input  logic signed [COORD_WIDTH-1:0]         req_c_z,
   input  logic                                  req_last_triangle,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic                                  rsp_hit,
   output logic [rtn_pkg::DIST_W-1:0]            rsp_distance,
   output logic [rtn_pkg::INDEX_W-1:0]           rsp_triangle_index
);
   import rtn_pkg::*;

   // The controller walks the micro-program; the datapath executes each step
   // and reports when a multi-cycle operation has finished.
   dp_cmd_type    cmd;
   dp_status_type status;

   rtn_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .cmd       (cmd),
      .status    (status)
   );

   rtn_datapath #(
      .COORD_WIDTH   (COORD_WIDTH),
      .FRACTION_BITS (FRACTION_BITS),
      .MAX_TRIANGLES (MAX_TRIANGLES)
   ) u_datapath (
      .clock              (clock),
      .reset              (reset),
      .csr_we             (csr_we),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata),
      .req_a_x            (req_a_x),
      .req_a_y            (req_a_y),
      .req_a_z            (req_a_z),
      .req_b_x            (req_b_x),
      .req_b_y            (req_b_y),
      .req_b_z            (req_b_z),
      .req_c_x            (req_c_x),
      .req_c_y            (req_c_y),
      .req_c_z            (req_c_z),
      .req_last_triangle  (req_last_triangle),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_hit            (rsp_hit),
      .rsp_distance       (rsp_distance),
      .rsp_triangle_index (rsp_triangle_index),
      .cmd                (cmd),
      .status             (status)
   );

endmodule
